// File: rtl/core/pfp_pkg.sv
`default_nettype none

package pfp_pkg;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ID_W     = 16;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;

    // frame delimiters and separators
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // frame kind text
    localparam logic [2:0]        KIND_LEN = 3'd4;
    localparam logic [BYTE_W-1:0] KIND_TEXT [4] = '{8'h50, 8'h49, 8'h4E, 8'h47};

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PONG      = 3'd0,
        ST_OWN       = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_NOT_PING  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    // one result item
    typedef struct packed {
        t_status              status;
        logic [ID_W-1:0]      peer_id;
        logic [VALUE_W-1:0]   sequence_res;
        logic [ID_W-1:0]      responder_id;
        logic [VALUE_W-1:0]   ping_total;
        logic [VALUE_W-1:0]   invalid_total;
    } t_result;

    // value * 10 + digit, saturating at all ones
    function automatic logic [VALUE_W-1:0] add_digit(input logic [VALUE_W-1:0] value,
                                                     input logic [3:0] digit);
        logic [VALUE_W+3:0] wide;
        wide = ({4'd0, value} << 3) + ({4'd0, value} << 1) + {{VALUE_W{1'b0}}, digit};
        if (wide[VALUE_W+3:VALUE_W] != 4'd0) begin
            return {VALUE_W{1'b1}};
        end
        return wide[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pfp_in_reg.sv
`default_nettype none

module pfp_in_reg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [pfp_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                        i_advance,
    output logic                             o_valid,
    output logic [pfp_pkg::BYTE_W-1:0]       o_byte
);
    import pfp_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // stage takes a new byte when empty or when the held byte moves on
    assign o_ready = !r_valid || i_advance;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // held byte
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// File: rtl/core/pfp_parse.sv
`default_nettype none

module pfp_parse #(
    parameter int unsigned FRAME_BYTES = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire logic [pfp_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic [pfp_pkg::ID_W-1:0]    i_my_id,
    output logic                             o_emit,
    output pfp_pkg::t_result                 o_res
);
    import pfp_pkg::*;

    localparam int unsigned     LEN_W = $clog2(FRAME_BYTES);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(FRAME_BYTES - 1);

    logic                r_in_frame,       n_in_frame;
    logic [LEN_W-1:0]    r_frame_length,   n_frame_length;
    logic                r_text_ended,     n_text_ended;
    logic [1:0]          r_field_number,   n_field_number;
    logic [2:0]          r_kind_position,  n_kind_position;
    logic                r_kind_mismatch,  n_kind_mismatch;
    logic [2:0]          r_field_nonempty, n_field_nonempty;
    logic [1:0]          r_digits_stopped, n_digits_stopped;
    logic [VALUE_W-1:0]  r_peer_value,     n_peer_value;
    logic [VALUE_W-1:0]  r_sequence_value, n_sequence_value;
    logic [VALUE_W-1:0]  r_ping_counter,   n_ping_counter;
    logic [VALUE_W-1:0]  r_invalid_counter, n_invalid_counter;

    logic                clear_frame;
    logic                is_digit;
    logic                digit_slot;
    t_status             status;
    logic [ID_W-1:0]     peer_out;
    logic [VALUE_W-1:0]  seq_out;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    // second field uses stop bit 0, third field stop bit 1
    assign digit_slot = r_field_number[1];

    // per-byte frame and field parsing
    always_comb begin
        n_in_frame        = r_in_frame;
        n_frame_length    = r_frame_length;
        n_text_ended      = r_text_ended;
        n_field_number    = r_field_number;
        n_kind_position   = r_kind_position;
        n_kind_mismatch   = r_kind_mismatch;
        n_field_nonempty  = r_field_nonempty;
        n_digits_stopped  = r_digits_stopped;
        n_peer_value      = r_peer_value;
        n_sequence_value  = r_sequence_value;
        n_ping_counter    = r_ping_counter;
        n_invalid_counter = r_invalid_counter;
        clear_frame       = 1'b0;
        o_emit            = 1'b0;
        status            = ST_PONG;
        peer_out          = '0;
        seq_out           = '0;

        if (i_advance) begin
            if (i_byte == CH_LT) begin
                n_in_frame  = 1'b1;
                clear_frame = 1'b1;
            end else if (r_in_frame) begin
                if (i_byte == CH_GT) begin
                    // frame end: judge the payload
                    n_in_frame  = 1'b0;
                    clear_frame = 1'b1;
                    o_emit      = 1'b1;
                    if (r_field_number != 2'd2 || r_field_nonempty != 3'b111) begin
                        status            = ST_MALFORMED;
                        n_invalid_counter = r_invalid_counter + 1'b1;
                    end else if (r_kind_mismatch || r_kind_position != KIND_LEN) begin
                        status            = ST_NOT_PING;
                        n_invalid_counter = r_invalid_counter + 1'b1;
                    end else begin
                        peer_out = r_peer_value[ID_W-1:0];
                        seq_out  = r_sequence_value;
                        if (r_peer_value[ID_W-1:0] == i_my_id) begin
                            status = ST_OWN;
                        end else begin
                            status         = ST_PONG;
                            n_ping_counter = r_ping_counter + 1'b1;
                        end
                    end
                end else if (i_byte == CH_CR || i_byte == CH_LF) begin
                    // line endings are skipped
                end else if (r_frame_length < LEN_LIMIT) begin
                    n_frame_length = r_frame_length + 1'b1;
                    if (!r_text_ended) begin
                        if (i_byte == CH_NUL) begin
                            n_text_ended = 1'b1;
                        end else if (i_byte == CH_COMMA && r_field_number != 2'd2) begin
                            n_field_number = r_field_number + 1'b1;
                        end else begin
                            n_field_nonempty = r_field_nonempty | (3'b001 << r_field_number);
                            if (r_field_number == 2'd0) begin
                                // kind field against the expected text
                                if (!r_kind_mismatch && r_kind_position < KIND_LEN &&
                                    i_byte == KIND_TEXT[r_kind_position[1:0]]) begin
                                    n_kind_position = r_kind_position + 1'b1;
                                end else begin
                                    n_kind_mismatch = 1'b1;
                                end
                            end else if (!r_digits_stopped[digit_slot]) begin
                                // leading decimal digits of a number field
                                if (is_digit) begin
                                    if (digit_slot) begin
                                        n_sequence_value = add_digit(r_sequence_value,
                                                                     i_byte[3:0]);
                                    end else begin
                                        n_peer_value = add_digit(r_peer_value, i_byte[3:0]);
                                    end
                                end else begin
                                    n_digits_stopped[digit_slot] = 1'b1;
                                end
                            end
                        end
                    end
                end else begin
                    // payload too long: abort the frame
                    n_in_frame        = 1'b0;
                    clear_frame       = 1'b1;
                    o_emit            = 1'b1;
                    status            = ST_OVERFLOW;
                    n_invalid_counter = r_invalid_counter + 1'b1;
                end
            end
        end

        if (clear_frame) begin
            n_frame_length   = '0;
            n_text_ended     = 1'b0;
            n_field_number   = '0;
            n_kind_position  = '0;
            n_kind_mismatch  = 1'b0;
            n_field_nonempty = '0;
            n_digits_stopped = '0;
            n_peer_value     = '0;
            n_sequence_value = '0;
        end
    end

    // result fields carry the counters after this byte
    always_comb begin
        o_res.status        = status;
        o_res.peer_id       = peer_out;
        o_res.sequence_res  = seq_out;
        o_res.responder_id  = i_my_id;
        o_res.ping_total    = n_ping_counter;
        o_res.invalid_total = n_invalid_counter;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame        <= 1'b0;
            r_frame_length    <= '0;
            r_text_ended      <= 1'b0;
            r_field_number    <= '0;
            r_kind_position   <= '0;
            r_kind_mismatch   <= 1'b0;
            r_field_nonempty  <= '0;
            r_digits_stopped  <= '0;
            r_peer_value      <= '0;
            r_sequence_value  <= '0;
            r_ping_counter    <= '0;
            r_invalid_counter <= '0;
        end else begin
            r_in_frame        <= n_in_frame;
            r_frame_length    <= n_frame_length;
            r_text_ended      <= n_text_ended;
            r_field_number    <= n_field_number;
            r_kind_position   <= n_kind_position;
            r_kind_mismatch   <= n_kind_mismatch;
            r_field_nonempty  <= n_field_nonempty;
            r_digits_stopped  <= n_digits_stopped;
            r_peer_value      <= n_peer_value;
            r_sequence_value  <= n_sequence_value;
            r_ping_counter    <= n_ping_counter;
            r_invalid_counter <= n_invalid_counter;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pfp_out_reg.sv
`default_nettype none

module pfp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire pfp_pkg::t_result  i_res,
    output logic                   o_free,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output pfp_pkg::t_result       o_res
);
    import pfp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result is taken this cycle
    assign o_free = !r_valid || i_ready;

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: rtl/core/ping_frame_parser_top.sv
// channel   direction  handshake                    payload
// rx        in         i_rx_valid / o_rx_ready      i_rx_byte
// result    out        o_res_valid / i_res_ready    o_status .. o_invalid_total
// config    in         i_cfg_we (no wait)           i_cfg_data (my_id)
//
// one byte per cycle unless a result stalls; each result is registered
// path: input register, parser logic and state, result register
// the parser moves a byte only when the result register is free, so a stalled
// result holds the input stage and o_rx_ready drops once that stage is full
// synchronous active-low reset clears state, counters and my_id

`default_nettype none

module ping_frame_parser_top #(
    parameter int unsigned FRAME_BYTES = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rx_valid,
    output logic                              o_rx_ready,
    input  wire logic [pfp_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire logic                         i_cfg_we,
    input  wire logic [pfp_pkg::ID_W-1:0]     i_cfg_data,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output logic [pfp_pkg::STATUS_W-1:0]      o_status,
    output logic [pfp_pkg::ID_W-1:0]          o_peer_id,
    output logic [pfp_pkg::VALUE_W-1:0]       o_sequence_res,
    output logic [pfp_pkg::ID_W-1:0]          o_responder_id,
    output logic [pfp_pkg::VALUE_W-1:0]       o_ping_total,
    output logic [pfp_pkg::VALUE_W-1:0]       o_invalid_total
);
    import pfp_pkg::*;

    logic [ID_W-1:0]   r_my_id;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_q;
    logic              advance;
    logic              out_free;
    logic              emit;
    t_result           parse_res;
    t_result           out_res;

    // own id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id <= '0;
        end else if (i_cfg_we) begin
            r_my_id <= i_cfg_data;
        end
    end

    // byte moves through the parser when the result side can take it
    assign advance = byte_valid && out_free;

    pfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx_valid),
        .o_ready   (o_rx_ready),
        .i_byte    (i_rx_byte),
        .i_advance (advance),
        .o_valid   (byte_valid),
        .o_byte    (byte_q)
    );

    pfp_parse #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (byte_q),
        .i_my_id   (r_my_id),
        .o_emit    (emit),
        .o_res     (parse_res)
    );

    pfp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_res   (parse_res),
        .o_free  (out_free),
        .i_ready (i_res_ready),
        .o_valid (o_res_valid),
        .o_res   (out_res)
    );

    // result fields to ports
    assign o_status        = out_res.status;
    assign o_peer_id       = out_res.peer_id;
    assign o_sequence_res  = out_res.sequence_res;
    assign o_responder_id  = out_res.responder_id;
    assign o_ping_total    = out_res.ping_total;
    assign o_invalid_total = out_res.invalid_total;

endmodule

`default_nettype wire

// File: rtl/core/pfp_checker.sv
`default_nettype none

module pfp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_rx_ready,
    input wire logic                         o_res_valid,
    input wire logic                         i_res_ready,
    input wire logic [pfp_pkg::STATUS_W-1:0] o_status,
    input wire logic [pfp_pkg::ID_W-1:0]     o_peer_id,
    input wire logic [pfp_pkg::VALUE_W-1:0]  o_sequence_res,
    input wire logic [pfp_pkg::ID_W-1:0]     o_responder_id
);
    import pfp_pkg::*;

    // a pending result is not withdrawn
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid)
        else $error("result request dropped while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result request after reset");

    // input back-pressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (o_res_valid && !i_res_ready))
        else $error("input stalled without a stalled result");

    // rejected frames carry no peer or sequence
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_status == ST_MALFORMED || o_status == ST_NOT_PING ||
                        o_status == ST_OVERFLOW)
        |-> (o_peer_id == '0 && o_sequence_res == '0))
        else $error("invalid result with peer or sequence set");

    // an ignored ping names our own id
    a_own_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == ST_OWN |-> o_peer_id == o_responder_id)
        else $error("own-id result with foreign peer id");

endmodule

bind ping_frame_parser_top pfp_checker u_pfp_checker (.*);

`default_nettype wire
